// ===== rtl/chtb_pkg.sv =====
// Shared types and constants of the consistent hash table builder.
`timescale 1ns / 1ps
`default_nettype none
package chtb_pkg;

	localparam int unsigned MAX_BACKENDS_DEF = 64;
	localparam int unsigned TABLE_DEPTH_DEF  = 4096;
	localparam logic [12:0] SLOT_LIMIT_RESET = 13'd4093;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_BUILD  = 2'd2;
	localparam logic [1:0] OP_LOOKUP = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_LIST_FULL  = 3'd1;
	localparam logic [2:0] ST_NO_BACKEND = 3'd2;
	localparam logic [2:0] ST_INCOMPLETE = 3'd3;
	localparam logic [2:0] ST_RANGE      = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_A,
		S_ADD_B,
		S_CLR,
		S_INIT_RD,
		S_INIT_WT,
		S_INIT_A,
		S_INIT_B,
		S_RND_RD,
		S_RND_LD,
		S_PROBE,
		S_CHECK,
		S_LOOK,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/chtb_div.sv =====
// Bit-serial restoring remainder unit: 32-bit dividend, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module chtb_div #(
	parameter int unsigned DW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      remainder
);

	logic [DW-1:0] rem_q;
	logic [31:0]   dvd_q;
	logic [DW-1:0] dvs_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	always_comb begin
		trial = {rem_q, dvd_q[31]};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[DW-1:0];
			end else begin
				rem_q <= trial[DW-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ===== rtl/consistent_hash_table_builder_core.sv =====
// Top level of the consistent hash table builder: backend list, build sequencer, lookups.
`timescale 1ns / 1ps
`default_nettype none
// Usage. Requests arrive on the s_ stream; the operation code rides in s_tuser and the
// two name hashes and the slot index in s_tdata. Every request yields exactly one
// response on the m_ stream carrying a status code and a backend identifier.
// The block handles one request at a time. A clear goes straight to its response and a
// lookup first reads its slot; the block goes idle when the response is registered.
// An add to a list with room runs two remainder operations in turn before it answers.
// A build first sweeps the slot memory, then computes each backend's start position
// and stride with the serial remainder unit, and then walks the permutations, visiting
// the backends in turn and moving on from a backend when its permutation runs out.
// The size register is written through cfg_we and cfg_data. The user must write it
// only while the block is idle; the block itself does not enforce this. Any write
// invalidates the current table until the next build.
// After reset (arst_n low) the backend list is empty, the table is not ready and
// the size register holds 4093. The slot memory contents are not cleared at reset;
// a build clears the slots it uses before filling them, and lookups answer only
// from a completed build.
// When the receiver stalls, the finished response sits in the output register; the
// block holds its next response until that one is taken, and it takes a new
// request only when its sequencer is idle.
module consistent_hash_table_builder_core #(
	parameter int unsigned MAX_BACKENDS = chtb_pkg::MAX_BACKENDS_DEF,
	parameter int unsigned TABLE_DEPTH  = chtb_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata: name_hash_a [31:0], name_hash_b [62:32], slot_index [74:63], zero pad
	input  wire logic [79:0] s_tdata,
	// s_tuser: opcode [1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata: status [2:0], backend_id [8:3], zero pad
	output logic [15:0]      m_tdata
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned BW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
	localparam int unsigned CW = $clog2(MAX_BACKENDS + 1);

	chtb_pkg::state_t state_q, state_d;

	logic [12:0]   slot_limit_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] filled_q;
	logic          ready_q;
	logic          progress_q;
	logic [BW-1:0] bk_idx_q;
	logic [SW-1:0] clr_cnt_q;
	logic [30:0]   hash_b_q;
	logic [SW-1:0] a_rem_q;
	logic [AW-1:0] cur_pos_q;
	logic [SW-1:0] cur_steps_q;
	logic [AW-1:0] cur_step_q;
	logic [AW-1:0] probe_pos_q;
	logic [2:0]    res_status_q;
	logic [5:0]    res_id_q;
	logic          m_valid_q;
	logic [2:0]    m_status_q;
	logic [5:0]    m_id_q;

	// Backend list: offset and stride as added; walk state per backend during a build.
	logic [2*AW-1:0]    bk_mem [MAX_BACKENDS];
	logic [2*AW+SW-1:0] pm_mem [MAX_BACKENDS];
	logic [CW-1:0]      sl_mem [TABLE_DEPTH];
	logic [2*AW-1:0]    bk_rd_q;
	logic [2*AW+SW-1:0] pm_rd_q;
	logic [CW-1:0]      sl_rd_q;

	logic [1:0]    opcode;
	logic [31:0]   hash_a;
	logic [11:0]   slot_index;
	logic          accept;
	logic [31:0]   ts_ext;
	logic [SW-1:0] size;
	logic          last_bk;
	logic [SW:0]   pos_sum;
	logic [AW-1:0] pos_next;
	logic [CW-1:0] owner;

	logic          div_start;
	logic [31:0]   div_dividend;
	logic [SW-1:0] div_divisor;
	logic          div_done;
	logic [SW-1:0] div_rem;

	logic          bk_we;
	logic          pm_we;
	logic          sl_we;
	logic [AW-1:0] sl_waddr;
	logic [CW-1:0] sl_wdata;
	logic [AW-1:0] sl_raddr;

	assign opcode     = s_tuser;
	assign hash_a     = s_tdata[31:0];
	assign slot_index = s_tdata[74:63];
	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == chtb_pkg::S_IDLE);

	// The size in effect is the register saturated to 2..TABLE_DEPTH.
	always_comb begin
		ts_ext = 32'(slot_limit_q);
		if (ts_ext < 32'd2) begin
			size = SW'(2);
		end else if (ts_ext > 32'(TABLE_DEPTH)) begin
			size = SW'(TABLE_DEPTH);
		end else begin
			size = SW'(ts_ext);
		end
	end

	assign last_bk  = ((CW'(bk_idx_q) + CW'(1)) == count_q);
	assign pos_sum  = (SW+1)'(cur_pos_q) + (SW+1)'(cur_step_q);
	assign pos_next = (pos_sum >= (SW+1)'(size)) ? AW'(pos_sum - (SW+1)'(size)) : AW'(pos_sum);
	assign owner    = CW'(bk_idx_q) + CW'(1);

	chtb_div #(
		.DW(SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chtb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, divider requests and memory write strobes.
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = hash_a;
		div_divisor  = size;
		bk_we        = 1'b0;
		pm_we        = 1'b0;
		sl_we        = 1'b0;
		sl_waddr     = AW'(clr_cnt_q);
		sl_wdata     = '0;
		sl_raddr     = AW'(slot_index);
		case (state_q)
			chtb_pkg::S_IDLE: begin
				if (accept) begin
					case (opcode)
						chtb_pkg::OP_CLEAR: state_d = chtb_pkg::S_RESP;
						chtb_pkg::OP_ADD: begin
							if (32'(count_q) >= 32'(MAX_BACKENDS)) begin
								state_d = chtb_pkg::S_RESP;
							end else begin
								div_start = 1'b1;
								state_d   = chtb_pkg::S_ADD_A;
							end
						end
						chtb_pkg::OP_BUILD: state_d = chtb_pkg::S_CLR;
						chtb_pkg::OP_LOOKUP: begin
							if (32'(slot_index) >= 32'(size) || !ready_q) begin
								state_d = chtb_pkg::S_RESP;
							end else begin
								state_d = chtb_pkg::S_LOOK;
							end
						end
						default: state_d = chtb_pkg::S_RESP;
					endcase
				end
			end
			chtb_pkg::S_ADD_A: begin
				div_dividend = {1'b0, hash_b_q};
				div_divisor  = size - SW'(1);
				if (div_done) begin
					div_start = 1'b1;
					state_d   = chtb_pkg::S_ADD_B;
				end
			end
			chtb_pkg::S_ADD_B: begin
				if (div_done) begin
					bk_we   = 1'b1;
					state_d = chtb_pkg::S_RESP;
				end
			end
			chtb_pkg::S_CLR: begin
				sl_we = 1'b1;
				if (clr_cnt_q == size - SW'(1)) begin
					state_d = (count_q == '0) ? chtb_pkg::S_RESP : chtb_pkg::S_INIT_RD;
				end
			end
			chtb_pkg::S_INIT_RD: state_d = chtb_pkg::S_INIT_WT;
			chtb_pkg::S_INIT_WT: begin
				div_dividend = 32'(bk_rd_q[2*AW-1:AW]);
				div_start    = 1'b1;
				state_d      = chtb_pkg::S_INIT_A;
			end
			chtb_pkg::S_INIT_A: begin
				div_dividend = 32'(bk_rd_q[AW-1:0]);
				if (div_done) begin
					div_start = 1'b1;
					state_d   = chtb_pkg::S_INIT_B;
				end
			end
			chtb_pkg::S_INIT_B: begin
				if (div_done) begin
					pm_we   = 1'b1;
					state_d = last_bk ? chtb_pkg::S_RND_RD : chtb_pkg::S_INIT_RD;
				end
			end
			chtb_pkg::S_RND_RD: state_d = chtb_pkg::S_RND_LD;
			chtb_pkg::S_RND_LD: state_d = chtb_pkg::S_PROBE;
			chtb_pkg::S_PROBE: begin
				sl_raddr = cur_pos_q;
				if (cur_steps_q >= size) begin
					// This permutation is used up; move on to the next backend.
					pm_we = 1'b1;
					if (last_bk && !progress_q) begin
						state_d = chtb_pkg::S_RESP;
					end else begin
						state_d = chtb_pkg::S_RND_RD;
					end
				end else begin
					state_d = chtb_pkg::S_CHECK;
				end
			end
			chtb_pkg::S_CHECK: begin
				sl_waddr = probe_pos_q;
				sl_wdata = owner;
				if (sl_rd_q == '0) begin
					sl_we = 1'b1;
					if (filled_q + SW'(1) == size) begin
						state_d = chtb_pkg::S_RESP;
					end else begin
						pm_we   = 1'b1;
						state_d = chtb_pkg::S_RND_RD;
					end
				end else begin
					state_d = chtb_pkg::S_PROBE;
				end
			end
			chtb_pkg::S_LOOK: state_d = chtb_pkg::S_RESP;
			chtb_pkg::S_RESP: begin
				if (!m_valid_q || m_tready) begin
					state_d = chtb_pkg::S_IDLE;
				end
			end
			default: state_d = chtb_pkg::S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= chtb_pkg::SLOT_LIMIT_RESET;
			count_q      <= '0;
			filled_q     <= '0;
			ready_q      <= 1'b0;
			progress_q   <= 1'b0;
			bk_idx_q     <= '0;
			clr_cnt_q    <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (state_q == chtb_pkg::S_RESP && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				chtb_pkg::S_IDLE: begin
					if (accept) begin
						if (opcode == chtb_pkg::OP_CLEAR) begin
							count_q <= '0;
							ready_q <= 1'b0;
						end
						if (opcode == chtb_pkg::OP_BUILD) begin
							ready_q   <= 1'b0;
							filled_q  <= '0;
							clr_cnt_q <= '0;
							bk_idx_q  <= '0;
						end
					end
				end
				chtb_pkg::S_ADD_B: begin
					if (div_done) begin
						count_q <= count_q + CW'(1);
						ready_q <= 1'b0;
					end
				end
				chtb_pkg::S_CLR: clr_cnt_q <= clr_cnt_q + SW'(1);
				chtb_pkg::S_INIT_B: begin
					if (div_done) begin
						progress_q <= 1'b0;
						bk_idx_q   <= last_bk ? '0 : bk_idx_q + BW'(1);
					end
				end
				chtb_pkg::S_PROBE: begin
					if (cur_steps_q >= size) begin
						if (last_bk) begin
							bk_idx_q   <= '0;
							progress_q <= 1'b0;
						end else begin
							bk_idx_q <= bk_idx_q + BW'(1);
						end
					end
				end
				chtb_pkg::S_CHECK: begin
					if (sl_rd_q == '0) begin
						filled_q <= filled_q + SW'(1);
						if (filled_q + SW'(1) == size) begin
							ready_q <= 1'b1;
						end else if (last_bk) begin
							bk_idx_q   <= '0;
							progress_q <= 1'b0;
						end else begin
							bk_idx_q   <= bk_idx_q + BW'(1);
							progress_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
			if (cfg_we) begin
				slot_limit_q <= cfg_data;
				ready_q      <= 1'b0;
			end
		end
	end

	// Payload registers and the response being assembled.
	always_ff @(posedge clk) begin
		case (state_q)
			chtb_pkg::S_IDLE: begin
				hash_b_q <= s_tdata[62:32];
				res_id_q <= '0;
				if (opcode == chtb_pkg::OP_ADD && 32'(count_q) >= 32'(MAX_BACKENDS)) begin
					res_status_q <= chtb_pkg::ST_LIST_FULL;
				end else if (opcode == chtb_pkg::OP_BUILD) begin
					res_status_q <= chtb_pkg::ST_NO_BACKEND;
				end else if (opcode == chtb_pkg::OP_LOOKUP && 32'(slot_index) >= 32'(size)) begin
					res_status_q <= chtb_pkg::ST_RANGE;
				end else if (opcode == chtb_pkg::OP_LOOKUP && !ready_q) begin
					res_status_q <= chtb_pkg::ST_INCOMPLETE;
				end else begin
					res_status_q <= chtb_pkg::ST_OK;
				end
			end
			chtb_pkg::S_ADD_A: if (div_done) a_rem_q <= div_rem;
			chtb_pkg::S_INIT_A: if (div_done) a_rem_q <= div_rem;
			chtb_pkg::S_RND_LD: begin
				cur_pos_q   <= pm_rd_q[2*AW+SW-1:AW+SW];
				cur_steps_q <= pm_rd_q[AW+SW-1:AW];
				cur_step_q  <= pm_rd_q[AW-1:0];
			end
			chtb_pkg::S_PROBE: begin
				if (cur_steps_q >= size) begin
					res_status_q <= chtb_pkg::ST_INCOMPLETE;
				end else begin
					probe_pos_q <= cur_pos_q;
					cur_pos_q   <= pos_next;
					cur_steps_q <= cur_steps_q + SW'(1);
				end
			end
			chtb_pkg::S_CHECK: res_status_q <= chtb_pkg::ST_OK;
			chtb_pkg::S_LOOK: res_id_q <= 6'(sl_rd_q - CW'(1));
			chtb_pkg::S_RESP: begin
				if (!m_valid_q || m_tready) begin
					m_status_q <= res_status_q;
					m_id_q     <= res_id_q;
				end
			end
			default: ;
		endcase
	end

	// Memories: one write port and one registered read port each.
	always_ff @(posedge clk) begin
		if (bk_we) begin
			bk_mem[BW'(count_q)] <= {AW'(a_rem_q), AW'(div_rem + SW'(1))};
		end
		bk_rd_q <= bk_mem[bk_idx_q];
	end

	always_ff @(posedge clk) begin
		if (pm_we) begin
			if (state_q == chtb_pkg::S_INIT_B) begin
				pm_mem[bk_idx_q] <= {AW'(a_rem_q), SW'(0), AW'(div_rem)};
			end else begin
				pm_mem[bk_idx_q] <= {cur_pos_q, cur_steps_q, cur_step_q};
			end
		end
		pm_rd_q <= pm_mem[bk_idx_q];
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			sl_mem[sl_waddr] <= sl_wdata;
		end
		sl_rd_q <= sl_mem[sl_raddr];
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_id_q, m_status_q};

	// A ready table always covers every slot in use.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> filled_q == size)
		else $error("table ready without all slots filled");

	// A lookup on a ready table always finds an owned slot.
	a_look_owned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == chtb_pkg::S_LOOK |-> sl_rd_q != '0)
		else $error("lookup hit an empty slot");

	// A slot check always follows the probe that issued its read.
	a_check_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == chtb_pkg::S_CHECK |-> $past(state_q) == chtb_pkg::S_PROBE)
		else $error("slot check without a probe");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(MAX_BACKENDS))
		else $error("backend count overflow");

endmodule
`default_nettype wire

// ===== test/chtb_checker.sv =====
// Checker for the consistent hash table builder: predicts every response and compares it.
`timescale 1ns / 1ps
`default_nettype none
module chtb_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [79:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	output int               errors,
	output int               outstanding
);

	localparam int NB = chtb_pkg::MAX_BACKENDS_DEF;
	localparam int ND = chtb_pkg::TABLE_DEPTH_DEF;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] backend_id;
	} answer_t;

	logic [12:0] size_reg;
	logic [11:0] off_mem  [NB];
	logic [11:0] skip_mem [NB];
	int unsigned pos_mem  [NB];
	int unsigned steps_mem[NB];
	logic [6:0]  owner_mem[ND];
	int unsigned num_backends;
	int unsigned filled;
	bit          ready;
	answer_t     answers_q[$];

	function automatic int unsigned active_size();
		int unsigned s;
		s = size_reg;
		if (s < 2) s = 2;
		if (s > ND) s = ND;
		return s;
	endfunction

	// Fills the slot table round-robin along each backend's permutation.
	function automatic logic [2:0] fill_slots();
		int unsigned sz;
		int unsigned stride;
		int unsigned p;
		bit progress;
		sz = active_size();
		for (int k = 0; k < ND; k++) owner_mem[k] = '0;
		filled = 0;
		ready = 0;
		if (num_backends == 0) return chtb_pkg::ST_NO_BACKEND;
		for (int i = 0; i < num_backends; i++) begin
			pos_mem[i] = off_mem[i] % sz;
			steps_mem[i] = 0;
		end
		forever begin
			progress = 0;
			for (int i = 0; i < num_backends; i++) begin
				stride = skip_mem[i] % sz;
				while (steps_mem[i] < sz) begin
					p = pos_mem[i];
					steps_mem[i]++;
					pos_mem[i] = p + stride;
					if (pos_mem[i] >= sz) pos_mem[i] -= sz;
					if (owner_mem[p] == 0) begin
						owner_mem[p] = 7'(i + 1);
						filled++;
						progress = 1;
						if (filled == sz) begin
							ready = 1;
							return chtb_pkg::ST_OK;
						end
						break;
					end
				end
			end
			if (!progress) return chtb_pkg::ST_INCOMPLETE;
		end
	endfunction

	function automatic answer_t apply_request(logic [1:0] op, logic [31:0] ha,
			logic [30:0] hb, logic [11:0] slot);
		answer_t a;
		int unsigned sz;
		sz = active_size();
		a = '0;
		case (op)
			chtb_pkg::OP_CLEAR: begin
				num_backends = 0;
				ready = 0;
			end
			chtb_pkg::OP_ADD: begin
				if (num_backends >= NB) begin
					a.status = chtb_pkg::ST_LIST_FULL;
				end else begin
					off_mem[num_backends] = 12'(ha % sz);
					skip_mem[num_backends] = 12'(hb % (sz - 1) + 1);
					num_backends++;
					ready = 0;
				end
			end
			chtb_pkg::OP_BUILD: a.status = fill_slots();
			default: begin
				if (slot >= sz) a.status = chtb_pkg::ST_RANGE;
				else if (!ready) a.status = chtb_pkg::ST_INCOMPLETE;
				else a.backend_id = 6'(owner_mem[slot] - 1);
			end
		endcase
		return a;
	endfunction

	initial begin
		errors = 0;
		outstanding = 0;
		size_reg = chtb_pkg::SLOT_LIMIT_RESET;
		num_backends = 0;
		filled = 0;
		ready = 0;
		for (int k = 0; k < ND; k++) owner_mem[k] = '0;
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (answers_q.size() == 0) begin
					$display("%0t: unexpected response expected none actual status=%0d id=%0d",
						$time, m_tdata[2:0], m_tdata[8:3]);
					errors++;
				end else begin
					want = answers_q.pop_front();
					if (m_tdata[2:0] !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, m_tdata[2:0]);
						errors++;
					end
					if (m_tdata[8:3] !== want.backend_id) begin
						$display("%0t: backend_id expected %0d actual %0d", $time,
							want.backend_id, m_tdata[8:3]);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				size_reg = cfg_data;
				ready = 0;
			end
			if (s_tvalid && s_tready)
				answers_q.push_back(apply_request(s_tuser, s_tdata[31:0], s_tdata[62:32],
					s_tdata[74:63]));
			outstanding = answers_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench top of the consistent hash table builder: stimulus, flow control and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int ITEM_TARGET = 450;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [12:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	int          errors;
	int          outstanding;
	int          cycles = 0;
	int          sent;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_req;

	consistent_hash_table_builder_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	chtb_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a build at the largest size is the slowest part of a correct run, and this
	// limit leaves a wide margin over it.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Response side. It idles at the current rate, and on request it holds off for a
	// long stretch so the block fills up and stops taking requests.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offers one request and waits for it to be taken.
	task automatic send_request(logic [1:0] op, logic [31:0] ha, logic [30:0] hb,
			logic [11:0] slot);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'd0, slot, hb, ha};
		do @(posedge clk); while (!s_tready);
		sent++;
		// Idle rates change with progress: the receiver idles more, then the sender does, then neither.
		if (sent < ITEM_TARGET / 3) begin
			send_idle_pct = 33;
			recv_idle_pct = 69;
		end else if (sent < 2 * ITEM_TARGET / 3) begin
			send_idle_pct = 69;
			recv_idle_pct = 33;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	// Drains all responses, lets the block settle, then writes the size register.
	task automatic write_size(logic [12:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic random_request();
		send_request(2'($urandom_range(3)), $urandom, 31'($urandom), 12'($urandom));
	endtask

	// One well-formed run: clear, a set of adds, a build, then lookups, with some noise.
	task automatic build_and_query(int eff_size);
		int n_add;
		int n_look;
		bit large_sz;
		large_sz = (eff_size > 200);
		n_add = large_sz ? $urandom_range(1, 4) : $urandom_range(1, 10);
		if (!large_sz && $urandom_range(9) == 0) n_add = 66;
		n_look = $urandom_range(5, 15);
		send_request(chtb_pkg::OP_CLEAR, $urandom, 31'($urandom), 12'($urandom));
		for (int i = 0; i < n_add; i++)
			send_request(chtb_pkg::OP_ADD, $urandom, 31'($urandom), 12'($urandom));
		send_request(chtb_pkg::OP_BUILD, $urandom, 31'($urandom), 12'($urandom));
		for (int i = 0; i < n_look; i++) begin
			if ($urandom_range(9) == 0) random_request();
			else if ($urandom_range(5) == 0)
				send_request(chtb_pkg::OP_LOOKUP, $urandom, 31'($urandom), 12'($urandom));
			else
				send_request(chtb_pkg::OP_LOOKUP, $urandom, 31'($urandom),
					12'($urandom_range(eff_size - 1)));
		end
		// A stray add or clear after the build checks that lookups see the table dropped.
		if ($urandom_range(3) == 0) begin
			send_request(2'($urandom_range(1)), $urandom, 31'($urandom), 12'($urandom));
			send_request(chtb_pkg::OP_LOOKUP, $urandom, 31'($urandom),
				12'($urandom_range(eff_size - 1)));
		end
	endtask

	initial begin
		logic [12:0] sizes[$];
		logic [12:0] sz;
		int eff;
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = chtb_pkg::OP_CLEAR;
		hold_req = 1'b0;
		sent = 0;
		send_idle_pct = 33;
		recv_idle_pct = 69;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. At the reset size nothing is built yet, and an index past the
		// size is rejected before readiness is checked.
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd5);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'hFFF);
		send_request(chtb_pkg::OP_BUILD, 32'd0, 31'd0, 12'd0);
		send_request(chtb_pkg::OP_CLEAR, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 12'hFFF);

		// Small prime table with extreme hashes, then lookups at both ends and past it.
		write_size(13'd7);
		send_request(chtb_pkg::OP_ADD, 32'd0, 31'd0, 12'd0);
		send_request(chtb_pkg::OP_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 12'd0);
		send_request(chtb_pkg::OP_ADD, 32'h8000_0000, 31'h4000_0000, 12'd0);
		send_request(chtb_pkg::OP_BUILD, 32'd0, 31'd0, 12'd0);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd0);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd6);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd7);
		send_request(chtb_pkg::OP_ADD, 32'd3, 31'd2, 12'd0);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd1);

		// A size write drops the table, and offsets stored at the old size are reduced
		// again by the build.
		write_size(13'd5);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd1);
		send_request(chtb_pkg::OP_BUILD, 32'd0, 31'd0, 12'd0);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd4);

		// Size 4 with one backend of stride 2 covers only half the slots: incomplete.
		write_size(13'd4);
		send_request(chtb_pkg::OP_CLEAR, 32'd0, 31'd0, 12'd0);
		send_request(chtb_pkg::OP_ADD, 32'd0, 31'd1, 12'd0);
		send_request(chtb_pkg::OP_BUILD, 32'd0, 31'd0, 12'd0);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd0);

		// Sizes below two saturate to two.
		write_size(13'd0);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd2);
		send_request(chtb_pkg::OP_BUILD, 32'd0, 31'd0, 12'd0);
		send_request(chtb_pkg::OP_LOOKUP, 32'd0, 31'd0, 12'd1);

		// Random part: each phase picks a size, the extremes among them, and runs one
		// or more build-and-query sequences.
		sizes = {13'd1, 13'd8191, 13'd2, 13'd3, 13'd13, 13'd4096, 13'd31, 13'd61,
			13'd11, 13'd4093, 13'd97, 13'd6, 13'd17, 13'd29, 13'd43, 13'd23, 13'd8};
		phase = 0;
		while (sent < ITEM_TARGET) begin
			if (phase < sizes.size())
				sz = sizes[phase];
			else
				sz = 13'($urandom_range(2, 127));
			write_size(sz);
			eff = (sz < 2) ? 2 : ((sz > 4096) ? 4096 : sz);
			if (phase == 3) hold_req = 1'b1;
			if (eff > 200) begin
				build_and_query(eff);
			end else begin
				for (int r = $urandom_range(1, 3); r > 0; r--) build_and_query(eff);
			end
			// Once, the sender stops until every response is back before going on.
			if (phase == 6) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			phase++;
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
